[hw/rtl/cfae_pkg.sv]
`default_nettype none
package cfae_pkg;

  localparam int QueueDepthDef = 4;

  localparam logic [15:0] MsWrap  = 16'd60000;
  localparam logic [31:0] UsWrap  = 32'd3600000000;
  localparam logic [9:0]  MsToUs  = 10'd1000;
  localparam logic [7:0]  CharCr  = 8'h0D;
  localparam logic [7:0]  CaseGap = 8'd32;

  localparam logic [1:0] FuncRx   = 2'd0;
  localparam logic [1:0] FuncTx   = 2'd1;
  localparam logic [1:0] FuncData = 2'd2;

  localparam logic [1:0] StampNone = 2'd0;
  localparam logic [1:0] StampMs   = 2'd1;
  localparam logic [1:0] StampUs   = 2'd2;
  localparam logic [1:0] StampBad  = 2'd3;

  localparam logic [7:0] RegStampMode = 8'd0;
  localparam logic [7:0] RegRepRx     = 8'd1;
  localparam logic [7:0] RegRepTx     = 8'd2;
  localparam logic [7:0] RegRepEsi    = 8'd3;

  typedef struct packed {
    logic [1:0] stamp_mode;
    logic       rep_rx;
    logic       rep_tx;
    logic       rep_esi;
  } cfg_t;

  typedef struct packed {
    logic        hdr;
    logic        prefix;
    logic        ext;
    logic [7:0]  type_char;
    logic [28:0] id;
    logic [3:0]  lc;
    logic [7:0]  data;
    logic        tail;
    logic [1:0]  smode;
    logic [31:0] stamp;
    logic        esi_en;
    logic        esi;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) c = 8'h30 + {4'b0, v};
    else c = 8'h41 + {4'b0, v} - 8'd10;
    return c;
  endfunction

  function automatic logic [6:0] len_bytes(input logic [3:0] lc);
    logic [6:0] n;
    case (lc)
      4'd9:    n = 7'd12;
      4'd10:   n = 7'd16;
      4'd11:   n = 7'd20;
      4'd12:   n = 7'd24;
      4'd13:   n = 7'd32;
      4'd14:   n = 7'd48;
      4'd15:   n = 7'd64;
      default: n = {3'b0, lc};
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/cfae_if.sv]
`default_nettype none
interface cfae_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        remote_frame;
  logic        fd_format;
  logic        rate_switch;
  logic        extended_id;
  logic [28:0] identifier;
  logic [3:0]  length_code;
  logic        error_passive;
  logic [15:0] capture_us;
  logic [31:0] now_ms;
  logic [7:0]  payload_byte;
  modport source (output valid, func, remote_frame, fd_format, rate_switch, extended_id,
                  identifier, length_code, error_passive, capture_us, now_ms, payload_byte,
                  input ready);
  modport sink (input valid, func, remote_frame, fd_format, rate_switch, extended_id,
                identifier, length_code, error_passive, capture_us, now_ms, payload_byte,
                output ready);
endinterface

interface cfae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       line_end;
  modport source (output valid, ascii_char, line_end, input ready);
  modport sink (input valid, ascii_char, line_end, output ready);
endinterface

interface cfae_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/cfae_front.sv]
`default_nettype none
module cfae_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  cfae_pkg::cfg_t     cfg_i,
  cfae_in_if.sink            in_i,
  input  wire logic          space_i,
  output logic               push_o,
  output cfae_pkg::job_t     job_o
);
  import cfae_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_ADD1 = 3'd2;
  localparam logic [2:0] F_ADD2 = 3'd3;
  localparam logic [2:0] F_MOD  = 3'd4;
  localparam logic [2:0] F_FIN  = 3'd5;

  logic [2:0]  fst_q;
  logic        frame_rep_q, fd_q, esi_q;
  logic [6:0]  bytes_left_q;
  logic [1:0]  fstamp_q;
  logic [31:0] last_tick_q, smic_q;
  logic [15:0] last_cap_q, smil_q;
  logic [3:0]  it_q;

  logic [31:0] dms_q;
  logic [15:0] dus_q;
  logic [41:0] prod_q;
  logic [63:0] x_q, val_q;
  logic [31:0] r_q;
  job_t        hjob_q;

  logic        acc, is_hdr, en;
  logic [6:0]  nbl;
  logic [7:0]  tchar;
  job_t        hdr_job, dat_job;
  logic [31:0] modulus, r_next;
  logic [32:0] r_acc;
  logic [16:0] ms_sum;
  logic [15:0] ms_new;

  assign in_i.ready = (fst_q == F_IDLE) && space_i;
  assign acc    = in_i.valid && in_i.ready;
  assign is_hdr = (in_i.func == FuncRx) || (in_i.func == FuncTx);
  assign en     = (in_i.func == FuncRx) ? cfg_i.rep_rx : cfg_i.rep_tx;
  assign nbl    = in_i.remote_frame ? 7'd0 : len_bytes(in_i.length_code);

  always_comb begin
    if (in_i.remote_frame) tchar = "r";
    else if (!in_i.fd_format) tchar = "t";
    else if (in_i.rate_switch) tchar = "b";
    else tchar = "d";
    if (in_i.extended_id) tchar = tchar - CaseGap;
  end

  always_comb begin
    hdr_job.hdr       = 1'b1;
    hdr_job.prefix    = (in_i.func == FuncTx);
    hdr_job.ext       = in_i.extended_id;
    hdr_job.type_char = tchar;
    hdr_job.id        = in_i.identifier;
    hdr_job.lc        = in_i.length_code;
    hdr_job.data      = 8'd0;
    hdr_job.tail      = (nbl == 7'd0);
    hdr_job.smode     = cfg_i.stamp_mode;
    hdr_job.stamp     = 32'd0;
    hdr_job.esi_en    = in_i.fd_format & cfg_i.rep_esi;
    hdr_job.esi       = in_i.error_passive;

    dat_job           = hdr_job;
    dat_job.hdr       = 1'b0;
    dat_job.data      = in_i.payload_byte;
    dat_job.tail      = (bytes_left_q == 7'd1);
    dat_job.smode     = fstamp_q;
    dat_job.stamp     = (fstamp_q == StampMs) ? {16'd0, smil_q} : smic_q;
    dat_job.esi_en    = fd_q;
    dat_job.esi       = esi_q;
  end

  // remainder step, four bits of the dividend a cycle
  assign modulus = (fstamp_q == StampMs) ? {16'd0, MsWrap} : UsWrap;
  always_comb begin
    r_acc = {1'b0, r_q};
    for (int k = 0; k < 4; k++) begin
      r_acc = {r_acc[31:0], val_q[63 - k]};
      if (r_acc >= {1'b0, modulus}) r_acc = r_acc - {1'b0, modulus};
    end
    r_next = r_acc[31:0];
  end

  assign ms_sum = {1'b0, r_q[15:0]} + {1'b0, smil_q};
  assign ms_new = (ms_sum >= {1'b0, MsWrap}) ? 16'(ms_sum - {1'b0, MsWrap}) : ms_sum[15:0];

  always_comb begin
    push_o = 1'b0;
    job_o  = hdr_job;
    if (fst_q == F_FIN) begin
      push_o = 1'b1;
      job_o  = hjob_q;
      job_o.stamp = (fstamp_q == StampMs) ? {16'd0, ms_new} : r_q;
    end else if (acc && is_hdr && en && cfg_i.stamp_mode == StampNone) begin
      push_o = 1'b1;
    end else if (acc && in_i.func == FuncData && bytes_left_q != 7'd0 && frame_rep_q) begin
      push_o = 1'b1;
      job_o  = dat_job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fst_q        <= F_IDLE;
      frame_rep_q  <= 1'b0;
      bytes_left_q <= 7'd0;
      fd_q         <= 1'b0;
      esi_q        <= 1'b0;
      fstamp_q     <= StampNone;
      last_tick_q  <= 32'd0;
      last_cap_q   <= 16'd0;
      smil_q       <= 16'd0;
      smic_q       <= 32'd0;
      it_q         <= 4'd0;
    end else begin
      case (fst_q)
        F_IDLE: begin
          if (acc && is_hdr) begin
            bytes_left_q <= nbl;
            frame_rep_q  <= en;
            if (en) begin
              fd_q     <= in_i.fd_format & cfg_i.rep_esi;
              esi_q    <= in_i.error_passive;
              fstamp_q <= cfg_i.stamp_mode;
              it_q     <= 4'd0;
              if (cfg_i.stamp_mode == StampMs) begin
                last_tick_q <= in_i.now_ms;
                fst_q       <= F_MOD;
              end else if (cfg_i.stamp_mode == StampUs) begin
                last_tick_q <= in_i.now_ms;
                last_cap_q  <= in_i.capture_us;
                fst_q       <= F_MUL;
              end
            end
          end else if (acc && in_i.func == FuncData && bytes_left_q != 7'd0) begin
            bytes_left_q <= bytes_left_q - 7'd1;
          end
        end
        F_MUL:  fst_q <= F_ADD1;
        F_ADD1: fst_q <= F_ADD2;
        F_ADD2: fst_q <= F_MOD;
        F_MOD: begin
          it_q <= it_q + 4'd1;
          if (it_q == 4'd15) fst_q <= F_FIN;
        end
        F_FIN: begin
          if (fstamp_q == StampMs) smil_q <= ms_new;
          else smic_q <= r_q;
          fst_q <= F_IDLE;
        end
        default: fst_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (fst_q)
      F_IDLE: begin
        hjob_q <= hdr_job;
        r_q    <= 32'd0;
        dms_q  <= in_i.now_ms - last_tick_q;
        dus_q  <= in_i.capture_us - last_cap_q;
        val_q  <= {32'd0, in_i.now_ms - last_tick_q};
      end
      F_MUL:  prod_q <= 42'(dms_q) * 42'(MsToUs);
      F_ADD1: x_q <= {22'd0, prod_q} + 64'd32768 - {48'd0, dus_q};
      F_ADD2: val_q <= {32'd0, smic_q} + {48'd0, dus_q} + {x_q[63:16], 16'd0};
      F_MOD: begin
        r_q   <= r_next;
        val_q <= {val_q[59:0], 4'd0};
      end
      default: r_q <= r_q;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/cfae_queue.sv]
`default_nettype none
module cfae_queue #(
  parameter int Depth = cfae_pkg::QueueDepthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  cfae_pkg::job_t            job_i,
  output logic                      space_o,
  output logic                      valid_o,
  input  wire logic                 pop_i,
  output cfae_pkg::job_t            job_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);
  import cfae_pkg::*;

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int Lw = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Lw-1:0] cnt_q;

  assign space_o = (cnt_q != Lw'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rp_q];
  assign level_o = cnt_q;

  function automatic logic [Aw-1:0] inc(input logic [Aw-1:0] p);
    return (p == Aw'(Depth - 1)) ? '0 : p + Aw'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= inc(wp_q);
      if (pop_i) rp_q <= inc(rp_q);
      cnt_q <= cnt_q + Lw'(push_i) - Lw'(pop_i);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cfae_back.sv]
`default_nettype none
module cfae_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  cfae_pkg::job_t job_i,
  output logic           pop_o,
  cfae_out_if.source     out_o
);
  import cfae_pkg::*;

  localparam logic [2:0] P_PRE   = 3'd0;
  localparam logic [2:0] P_TYPE  = 3'd1;
  localparam logic [2:0] P_ID    = 3'd2;
  localparam logic [2:0] P_DLC   = 3'd3;
  localparam logic [2:0] P_DATA  = 3'd4;
  localparam logic [2:0] P_STAMP = 3'd5;
  localparam logic [2:0] P_ESI   = 3'd6;
  localparam logic [2:0] P_CR    = 3'd7;

  logic       busy_q, ov_q, oe_q;
  logic [7:0] oc_q;
  logic [2:0] ph_q, cnt_q;
  job_t       job_q;

  logic       adv, last;
  logic [2:0] nph, ncnt, tph, tcnt;
  logic [7:0] ch;
  logic [31:0] idw;

  assign idw = {3'd0, job_q.id};

  // first step of the line tail
  always_comb begin
    tcnt = 3'd0;
    if (job_q.smode == StampMs) begin
      tph = P_STAMP; tcnt = 3'd3;
    end else if (job_q.smode == StampUs) begin
      tph = P_STAMP; tcnt = 3'd7;
    end else if (job_q.esi_en) begin
      tph = P_ESI;
    end else begin
      tph = P_CR;
    end
  end

  always_comb begin
    nph  = ph_q;
    ncnt = cnt_q;
    last = 1'b0;
    case (ph_q)
      P_PRE:  nph = P_TYPE;
      P_TYPE: begin
        nph  = P_ID;
        ncnt = job_q.ext ? 3'd7 : 3'd2;
      end
      P_ID: begin
        if (cnt_q == 3'd0) nph = P_DLC;
        else ncnt = cnt_q - 3'd1;
      end
      P_DLC: begin
        if (job_q.tail) begin
          nph = tph; ncnt = tcnt;
        end else last = 1'b1;
      end
      P_DATA: begin
        if (cnt_q != 3'd0) ncnt = cnt_q - 3'd1;
        else if (job_q.tail) begin
          nph = tph; ncnt = tcnt;
        end else last = 1'b1;
      end
      P_STAMP: begin
        if (cnt_q != 3'd0) ncnt = cnt_q - 3'd1;
        else nph = job_q.esi_en ? P_ESI : P_CR;
      end
      P_ESI:  nph = P_CR;
      P_CR:   last = 1'b1;
      default: last = 1'b1;
    endcase
  end

  always_comb begin
    case (ph_q)
      P_PRE:   ch = job_q.ext ? "Z" : "z";
      P_TYPE:  ch = job_q.type_char;
      P_ID:    ch = hex_char(idw[{cnt_q, 2'b00} +: 4]);
      P_DLC:   ch = hex_char(job_q.lc);
      P_DATA:  ch = hex_char(cnt_q[0] ? job_q.data[7:4] : job_q.data[3:0]);
      P_STAMP: ch = hex_char(job_q.stamp[{cnt_q, 2'b00} +: 4]);
      P_ESI:   ch = job_q.esi ? "1" : "0";
      P_CR:    ch = CharCr;
      default: ch = CharCr;
    endcase
  end

  assign adv   = busy_q && (!ov_q || out_o.ready);
  assign pop_o = valid_i && (!busy_q || (adv && last));

  assign out_o.valid      = ov_q;
  assign out_o.ascii_char = oc_q;
  assign out_o.line_end   = oe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
      ph_q   <= P_PRE;
      cnt_q  <= 3'd0;
    end else begin
      if (adv) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
      if (pop_o) begin
        busy_q <= 1'b1;
        if (!job_i.hdr) begin
          ph_q <= P_DATA; cnt_q <= 3'd1;
        end else begin
          ph_q <= job_i.prefix ? P_PRE : P_TYPE; cnt_q <= 3'd0;
        end
      end else if (adv) begin
        busy_q <= !last;
        ph_q   <= nph;
        cnt_q  <= ncnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (adv) begin
      oc_q <= ch;
      oe_q <= (ph_q == P_CR);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/can_frame_to_ascii_line_encoder_core.sv]
// a reported header item without stamp is pushed into the queue when accepted; a stamped one
// first passes the stamp unit (MUL, ADD1, ADD2 for us stamps, then the remainder unit)
// throughput: one character per cycle when not stalled; a payload item gives two digits
// a stamped header holds input ready low while the stamp unit works
// reset: asynchronous, clears control state, stamps and config registers to defaults
`default_nettype none
module can_frame_to_ascii_line_encoder_core #(
  parameter int QueueDepth = cfae_pkg::QueueDepthDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cfae_in_if.sink    in_i,
  cfae_cfg_if.sink   cfg_i,
  cfae_out_if.source out_o
);
  import cfae_pkg::*;

  cfg_t cfg_q;
  logic push, space, qvalid, pop;
  job_t fjob, qjob;
  logic [$clog2(QueueDepth+1)-1:0] level;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stamp_mode <= StampNone;
      cfg_q.rep_rx     <= 1'b1;
      cfg_q.rep_tx     <= 1'b0;
      cfg_q.rep_esi    <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegStampMode: if (cfg_i.data[1:0] != StampBad) cfg_q.stamp_mode <= cfg_i.data[1:0];
        RegRepRx:     cfg_q.rep_rx  <= cfg_i.data[0];
        RegRepTx:     cfg_q.rep_tx  <= cfg_i.data[0];
        RegRepEsi:    cfg_q.rep_esi <= cfg_i.data[0];
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  cfae_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_i,
    .space_i(space), .push_o(push), .job_o(fjob)
  );

  cfae_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(fjob), .space_o(space),
    .valid_o(qvalid), .pop_i(pop), .job_o(qjob), .level_o(level)
  );

  cfae_back u_back (
    .clk_i, .rst_ni, .valid_i(qvalid), .job_i(qjob), .pop_o(pop), .out_o
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.line_end |-> out_o.ascii_char == CharCr)
    else $error("line end on a character other than CR");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= ($clog2(QueueDepth+1))'(QueueDepth))
    else $error("queue level above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !(level == ($clog2(QueueDepth+1))'(QueueDepth) && !pop))
    else $error("push into full queue");

endmodule
`default_nettype wire

[sim/tb_can_frame_to_ascii_line_encoder_core.sv]
module tb_can_frame_to_ascii_line_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cfae_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } char_t;

  typedef struct {
    logic [1:0]  func;
    logic        remote;
    logic        fd;
    logic        brs;
    logic        ext;
    logic [28:0] id;
    logic [3:0]  lc;
    logic        esi;
    logic [15:0] cap;
    logic [31:0] now;
    logic [7:0]  data;
  } item_t;

  // text line predictor plus queue of pending characters
  class line_scoreboard;
    logic [1:0]  smode = StampNone;
    logic        rep_rx = 1'b1;
    logic        rep_tx = 1'b0;
    logic        rep_esi = 1'b0;
    logic        reporting = 0;
    logic [6:0]  left = 0;
    logic        esi_on = 0;
    logic        esi_val = 0;
    logic [1:0]  fstamp = 0;
    logic [31:0] tick = 0;
    logic [15:0] lcap = 0;
    logic [15:0] millis = 0;
    logic [31:0] micros = 0;
    char_t       pending[$];
    int          errors = 0;
    int          chars = 0;
    int          lines = 0;

    function void write_reg(logic [7:0] idx, logic [7:0] val);
      if (idx == RegStampMode) begin
        if (val[1:0] != StampBad) smode = val[1:0];
      end else if (idx == RegRepRx) rep_rx = val[0];
      else if (idx == RegRepTx) rep_tx = val[0];
      else if (idx == RegRepEsi) rep_esi = val[0];
    endfunction

    function logic [7:0] hexdig(logic [3:0] v);
      return (v < 10) ? 8'h30 + v : 8'h37 + v;
    endfunction

    function void push(logic [7:0] c, logic e);
      char_t t;
      t.ch = c;
      t.eol = e;
      pending.push_back(t);
    endfunction

    function void push_hex(logic [31:0] v, int n);
      for (int i = n - 1; i >= 0; i--) push(hexdig(v[4*i +: 4]), 1'b0);
    endfunction

    function void push_tail();
      if (fstamp == StampMs) push_hex(millis, 4);
      else if (fstamp == StampUs) push_hex(micros, 8);
      if (esi_on) push(esi_val ? "1" : "0", 1'b0);
      push(CharCr, 1'b1);
    endfunction

    function void advance_stamp(logic [31:0] now, logic [15:0] cap);
      logic [31:0] dms;
      logic [63:0] dus;
      logic [63:0] n;
      dms = now - tick;
      if (smode == StampMs) begin
        millis = 16'((32'(millis) + dms % 60000) % 60000);
        tick = now;
      end else if (smode == StampUs) begin
        dus = 64'(16'(cap - lcap));
        n = 64'(dms) * 64'd1000 - dus + 64'd32768;
        n = n >> 16;
        dus = dus + (n << 16);
        micros = 32'((64'(micros) + dus) % 64'd3600000000);
        tick = now;
        lcap = cap;
      end
    endfunction

    function void note_item(item_t it);
      logic [7:0] ty;
      if (it.func == FuncRx || it.func == FuncTx) begin
        left = it.remote ? 7'd0 : len_table(it.lc);
        reporting = (it.func == FuncRx) ? rep_rx : rep_tx;
        if (!reporting) return;
        esi_on = it.fd & rep_esi;
        esi_val = it.esi;
        fstamp = smode;
        if (it.func == FuncTx) push(it.ext ? "Z" : "z", 1'b0);
        if (it.remote) ty = "r";
        else if (!it.fd) ty = "t";
        else ty = it.brs ? "b" : "d";
        push(it.ext ? ty - 8'd32 : ty, 1'b0);
        push_hex(32'(it.id), it.ext ? 8 : 3);
        push(hexdig(it.lc), 1'b0);
        advance_stamp(it.now, it.cap);
        if (left == 0) push_tail();
      end else if (it.func == FuncData && left != 0) begin
        left--;
        if (!reporting) return;
        push_hex(32'(it.data), 2);
        if (left == 0) push_tail();
      end
    endfunction

    function logic [6:0] len_table(logic [3:0] lc);
      case (lc)
        9: return 7'd12;
        10: return 7'd16;
        11: return 7'd20;
        12: return 7'd24;
        13: return 7'd32;
        14: return 7'd48;
        15: return 7'd64;
        default: return 7'(lc);
      endcase
    endfunction

    function void check_char(logic [7:0] c, logic e);
      char_t x;
      chars++;
      if (e) lines++;
      if (pending.size() == 0) begin
        $error("unexpected character %h", c);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (x.ch !== c) begin
        $error("ascii_char expected %h actual %h", x.ch, c);
        errors++;
      end
      if (x.eol !== e) begin
        $error("line_end expected %b actual %b", x.eol, e);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  always #6 clk_i = ~clk_i;

  cfae_in_if  in_if();
  cfae_out_if out_if();
  cfae_cfg_if cfg_if();

  can_frame_to_ascii_line_encoder_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink), .cfg_i(cfg_if.sink),
    .out_o(out_if.source)
  );

  line_scoreboard sb = new();
  longint cycles = 0;
  bit hold_long = 0;
  int burst = 0;
  int items_sent = 0;

  initial begin
    in_if.valid = 0; in_if.func = 0; in_if.remote_frame = 0; in_if.fd_format = 0;
    in_if.rate_switch = 0; in_if.extended_id = 0; in_if.identifier = 0;
    in_if.length_code = 0; in_if.error_passive = 0; in_if.capture_us = 0;
    in_if.now_ms = 0; in_if.payload_byte = 0;
    cfg_if.valid = 0; cfg_if.index = 0; cfg_if.data = 0;
    out_if.ready = 0;
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (hold_long) out_if.ready <= 0;
    else case ((cycles / 64) % 4)
      0: out_if.ready <= 1;
      1: out_if.ready <= ($urandom_range(0, 3) != 0);
      2: out_if.ready <= ($urandom_range(0, 1) != 0);
      default: out_if.ready <= ((cycles % 7) != 3);
    endcase
    if (rst_ni && out_if.valid && out_if.ready) sb.check_char(out_if.ascii_char, out_if.line_end);
  end

  always @(posedge clk_i) begin
    if (cycles > 2000000) begin
      $display("tb_can_frame_to_ascii_line_encoder_core: FAIL");
      $finish;
    end
  end

  task automatic send(item_t it, bit gaps);
    int n;
    cfg_if.valid <= 0;
    if (gaps) begin
      if (burst == 0) begin
        n = $urandom_range(0, 6);
        if (n != 0) begin
          in_if.valid <= 0;
          repeat (n) @(posedge clk_i);
        end
        burst = $urandom_range(1, 12);
      end
      burst--;
    end
    in_if.valid <= 1;
    in_if.func <= it.func; in_if.remote_frame <= it.remote; in_if.fd_format <= it.fd;
    in_if.rate_switch <= it.brs; in_if.extended_id <= it.ext; in_if.identifier <= it.id;
    in_if.length_code <= it.lc; in_if.error_passive <= it.esi; in_if.capture_us <= it.cap;
    in_if.now_ms <= it.now; in_if.payload_byte <= it.data;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_if.valid <= 0;
    cfg_if.valid <= 0;
    while (sb.pending.size() != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  function automatic item_t rand_header(int mix);
    item_t it;
    it.func = ($urandom_range(0, 3) == 0) ? FuncTx : FuncRx;
    it.remote = ($urandom_range(0, 7) == 0);
    it.fd = 1'($urandom_range(0, 1));
    it.brs = 1'($urandom_range(0, 1));
    it.ext = 1'($urandom_range(0, 1));
    it.id = 29'($urandom());
    it.lc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    it.esi = 1'($urandom_range(0, 1));
    it.cap = 16'($urandom());
    it.now = (mix == 0) ? $urandom() : 32'($urandom_range(0, 5000));
    it.data = 8'($urandom());
    return it;
  endfunction

  // header followed by its payload; sometimes cut short or padded
  task automatic send_frame(item_t h, bit gaps, logic [31:0] base);
    item_t d;
    int n;
    h.now = base + h.now;
    send(h, gaps);
    n = h.remote ? 0 : int'(sb.len_table(h.lc));
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n + 2);
    for (int i = 0; i < n; i++) begin
      d = rand_header(1);
      d.func = FuncData;
      send(d, gaps);
    end
  endtask

  initial begin
    item_t it;
    logic [31:0] clock_ms;
    clock_ms = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    repeat (3) @(posedge clk_i);

    // directed
    write_reg(RegRepTx, 8'd1);
    write_reg(RegRepEsi, 8'd1);
    it = rand_header(1);
    it.func = FuncRx; it.ext = 0; it.id = '1; it.lc = 0; it.remote = 0; it.fd = 0;
    send(it, 0);
    it.func = FuncTx; it.ext = 1; it.id = '1; it.remote = 1; it.lc = 4'hF;
    send(it, 0);
    it.func = FuncData; it.data = 8'hFF;
    send(it, 0); // surplus byte
    it.func = 2'd3;
    send(it, 0); // unused func
    it.func = FuncRx; it.remote = 0; it.fd = 1; it.brs = 1; it.ext = 0; it.id = 0;
    it.lc = 4'd2; it.esi = 1;
    send(it, 0);
    it.func = FuncData; it.data = 8'h00; send(it, 0);
    it.data = 8'hA5; send(it, 0);
    it.func = FuncTx; it.fd = 1; it.brs = 0; it.ext = 1; it.lc = 4'd9; it.esi = 0;
    send(it, 0);
    it.func = FuncData; it.data = 8'h5A; send(it, 0);
    it.func = FuncRx; it.fd = 0; it.lc = 4'd1; send(it, 0); // abandons the old line
    it.func = FuncData; send(it, 0);
    drain();
    write_reg(RegStampMode, 8'(StampMs));
    write_reg(RegStampMode, 8'(StampBad));
    write_reg(8'd200, 8'hFF);
    it = rand_header(0); it.func = FuncRx; it.remote = 1; send(it, 0);
    it.now = 32'hFFFF_FFFF; send(it, 0);
    it.now = 32'd5; send(it, 0);
    drain();
    write_reg(RegStampMode, 8'(StampUs));
    it.cap = 16'hFFFF; it.now = 32'd10; send(it, 0);
    it.cap = 16'd0; it.now = 32'd4000000; send(it, 0);
    drain();
    write_reg(RegRepRx, 8'd0);
    it.func = FuncRx; it.remote = 0; it.lc = 4'd3; send(it, 0);
    it.func = FuncData; send(it, 0); send(it, 0); send(it, 0);
    drain();

    // long receiver hold-off so the block backs up
    fork
      begin
        hold_long = 1;
        repeat (400) @(posedge clk_i);
        hold_long = 0;
      end
      for (int i = 0; i < 20; i++) begin
        it = rand_header(1); it.func = FuncTx; it.remote = 0; it.lc = 4'd1;
        send(it, 0);
        it.func = FuncData; send(it, 0);
      end
    join
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegStampMode, 8'(ph % 3));
      write_reg(RegRepRx, (ph == 4) ? 8'd0 : 8'd1);
      write_reg(RegRepTx, 8'(ph % 2));
      write_reg(RegRepEsi, 8'((ph / 2) % 2));
      for (int k = 0; k < 6; k++) begin
        clock_ms = clock_ms + $urandom_range(0, 3000);
        if ($urandom_range(0, 9) == 0) begin
          it = rand_header(0);
          it.func = 2'($urandom_range(2, 3));
          send(it, 1);
        end else begin
          send_frame(rand_header(2), 1, clock_ms);
        end
      end
      drain();
    end

    $display("sent %0d items, checked %0d characters in %0d lines", items_sent, sb.chars,
             sb.lines);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_can_frame_to_ascii_line_encoder_core: PASS");
    end else begin
      if (sb.pending.size() != 0) $error("%0d characters never arrived", sb.pending.size());
      $display("tb_can_frame_to_ascii_line_encoder_core: FAIL");
    end
    $finish;
  end
endmodule

[can_frame_to_ascii_line_encoder_core.f]
hw/rtl/cfae_pkg.sv
hw/rtl/cfae_if.sv
hw/rtl/cfae_front.sv
hw/rtl/cfae_queue.sv
hw/rtl/cfae_back.sv
hw/rtl/can_frame_to_ascii_line_encoder_core.sv
sim/tb_can_frame_to_ascii_line_encoder_core.sv
